FILE: rtl/hcsp_pkg.sv
// hcsp_pkg: shared types and constants of the hex color string parser
// no dependencies; imported by every rtl module of the parser
package hcsp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_BAD_DIGIT   = 3'd2,
    ST_BAD_PATTERN = 3'd3,
    ST_ALPHA_REQ   = 3'd4
  } status_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WITH_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_ALPHA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERMISSIVE  = 2'd2;

  // configuration as seen by the formatter
  typedef struct packed {
    logic with_alpha_mode;
    logic require_alpha;
    logic permissive;
  } cfg_t;

  // string state after the current character
  typedef struct packed {
    logic [3:0]  digit_count;
    logic [31:0] hex_acc;
    logic        saw_bad_digit;
  } str_t;

  // one result item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    status_t    status;
  } color_t;

endpackage

FILE: rtl/hcsp_char_if.sv
// hcsp_char_if: character input channel of the hex color string parser
// no dependencies
interface hcsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       is_empty;

  modport source (output valid, char_code, is_last, is_empty, input ready);
  modport sink   (input valid, char_code, is_last, is_empty, output ready);
endinterface

FILE: rtl/hcsp_color_if.sv
// hcsp_color_if: result channel of the hex color string parser
// no dependencies
interface hcsp_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [2:0] status;

  modport source (output valid, red, green, blue, alpha, status, input ready);
  modport sink   (input valid, red, green, blue, alpha, status, output ready);
endinterface

FILE: rtl/hcsp_cfg_if.sv
// hcsp_cfg_if: configuration write channel of the hex color string parser
// no dependencies
interface hcsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hcsp_state.sv
// hcsp_state: digit decode and per-string state (count, accumulator, flags)
// depends on hcsp_pkg
module hcsp_state import hcsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,       // item in the input register is consumed
  input  logic [7:0] char_code,
  input  logic       is_last,
  input  logic       is_empty,
  output str_t       snap         // state including the current character
);

  localparam logic [3:0] COUNT_MAX = 4'd9;
  localparam logic [7:0] HASH_CHAR = 8'h23;

  str_t cur;
  logic at_first_char;
  logic hash_skip;
  logic nib_ok;
  logic [3:0] nib;

  // hex digit decode
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      nib = 4'(char_code - 8'h30);
    end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
      nib = 4'(char_code - 8'h57);
    end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
      nib = 4'(char_code - 8'h37);
    end else begin
      nib_ok = 1'b0;
    end
  end

  // fold the current character into the string state
  assign hash_skip = at_first_char && (char_code == HASH_CHAR);

  always_comb begin
    snap = cur;
    if (!hash_skip) begin
      if (cur.digit_count < COUNT_MAX) begin
        snap.digit_count = cur.digit_count + 4'd1;
      end
      if (nib_ok) begin
        snap.hex_acc = {cur.hex_acc[27:0], nib};
      end else begin
        snap.saw_bad_digit = 1'b1;
      end
    end
  end

  // state registers, cleared after every emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      at_first_char <= 1'b1;
    end else if (step) begin
      if (is_last || is_empty) begin
        cur           <= '0;
        at_first_char <= 1'b1;
      end else begin
        cur           <= snap;
        at_first_char <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/hcsp_format.sv
// hcsp_format: picks the color format from the digit count and checks errors
// depends on hcsp_pkg
module hcsp_format import hcsp_pkg::*; (
  input  str_t   snap,
  input  logic   is_empty,
  input  cfg_t   cfg,
  output color_t color
);

  localparam logic [3:0] LIMIT_RGBA = 4'd8;
  localparam logic [3:0] LIMIT_RGB  = 4'd6;
  localparam logic [7:0] FULL       = 8'hFF;

  logic [3:0]  n;
  logic [31:0] v;
  logic [3:0]  limit;
  logic        alpha_missing_err;

  assign n     = snap.digit_count;
  assign v     = snap.hex_acc;
  assign limit = cfg.with_alpha_mode ? LIMIT_RGBA : LIMIT_RGB;
  assign alpha_missing_err = cfg.with_alpha_mode && cfg.require_alpha;

  // checks in order: empty, too long, bad digit, then pattern by length
  always_comb begin
    color        = '0;
    color.status = ST_OK;
    priority if (is_empty) begin
      if (cfg.permissive) begin
        color.red   = FULL;
        color.green = FULL;
        color.blue  = FULL;
        color.alpha = FULL;
      end else begin
        color.status = ST_BAD_DIGIT;
      end
    end else if (n > limit) begin
      color.status = ST_TOO_LONG;
    end else if (snap.saw_bad_digit || n == 4'd0) begin
      color.status = ST_BAD_DIGIT;
    end else begin
      unique case (n)
        4'd8: begin
          color.red   = v[31:24];
          color.green = v[23:16];
          color.blue  = v[15:8];
          color.alpha = v[7:0];
        end
        4'd6: begin
          if (alpha_missing_err) begin
            color.status = ST_ALPHA_REQ;
          end else begin
            color.red   = v[23:16];
            color.green = v[15:8];
            color.blue  = v[7:0];
            color.alpha = FULL;
          end
        end
        4'd4: begin
          if (cfg.with_alpha_mode) begin
            color.red   = {v[15:12], v[15:12]};
            color.green = {v[11:8], v[11:8]};
            color.blue  = {v[7:4], v[7:4]};
            color.alpha = {v[3:0], v[3:0]};
          end else begin
            color.status = ST_BAD_PATTERN;
          end
        end
        4'd3: begin
          if (alpha_missing_err) begin
            color.status = ST_ALPHA_REQ;
          end else begin
            color.red   = {v[11:8], v[11:8]};
            color.green = {v[7:4], v[7:4]};
            color.blue  = {v[3:0], v[3:0]};
            color.alpha = FULL;
          end
        end
        4'd2, 4'd1: begin
          // grey forms, only in permissive mode
          if (!cfg.permissive) begin
            color.status = ST_BAD_PATTERN;
          end else if (alpha_missing_err) begin
            color.status = ST_ALPHA_REQ;
          end else begin
            color.red   = (n == 4'd2) ? v[7:0] : {v[3:0], v[3:0]};
            color.green = color.red;
            color.blue  = color.red;
            color.alpha = FULL;
          end
        end
        default: begin
          color.status = ST_BAD_PATTERN;
        end
      endcase
    end
  end

endmodule

FILE: rtl/hex_color_string_parser_unit.sv
// hex_color_string_parser_unit: top level of the hex color string parser
// depends on hcsp_pkg, hcsp_char_if, hcsp_color_if, hcsp_cfg_if, hcsp_state, hcsp_format
//
//   channel    dir  payload                                   handshake
//   char_in    in   char_code[7:0] is_last is_empty           valid/ready
//   color_out  out  red green blue alpha[7:0] status[2:0]     valid/ready
//   cfg        in   index[1:0] data                           valid/ready, always ready
//
// one character per cycle while no final item waits for a free result slot
// path: input register, then state update and format logic, then result register
// rst (synchronous) clears the config to four-component rules and empties the string
// a stalled result holds the input register only when that item also ends a string
module hex_color_string_parser_unit import hcsp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  hcsp_char_if.sink       char_in,
  hcsp_color_if.source    color_out,
  hcsp_cfg_if.sink        cfg
);

  cfg_t       cfg_reg;
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       in_empty;
  logic       ends_string;
  logic       step;
  logic       out_valid;
  color_t     out_color;
  color_t     color_next;
  str_t       snap;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.with_alpha_mode <= 1'b1;
      cfg_reg.require_alpha   <= 1'b0;
      cfg_reg.permissive      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WITH_ALPHA: cfg_reg.with_alpha_mode <= cfg.data;
        CFG_REQ_ALPHA:  cfg_reg.require_alpha   <= cfg.data;
        CFG_PERMISSIVE: cfg_reg.permissive      <= cfg.data;
        default: ;
      endcase
    end
  end

  // advance rule: non-final items always move, final ones need a free result slot
  assign ends_string  = in_last || in_empty;
  assign step         = in_valid && (!ends_string || !out_valid || color_out.ready);
  assign char_in.ready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      in_char  <= char_in.char_code;
      in_last  <= char_in.is_last;
      in_empty <= char_in.is_empty;
    end
  end

  // string state
  hcsp_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (in_char),
    .is_last   (in_last),
    .is_empty  (in_empty),
    .snap      (snap)
  );

  // format selection and error checks
  hcsp_format u_format (
    .snap     (snap),
    .is_empty (in_empty),
    .cfg      (cfg_reg),
    .color    (color_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && ends_string) begin
      out_valid <= 1'b1;
    end else if (color_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ends_string) begin
      out_color <= color_next;
    end
  end

  assign color_out.valid  = out_valid;
  assign color_out.red    = out_color.red;
  assign color_out.green  = out_color.green;
  assign color_out.blue   = out_color.blue;
  assign color_out.alpha  = out_color.alpha;
  assign color_out.status = out_color.status;

`ifndef NO_ASSERTIONS
  // an error result carries no color
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_color.status != ST_OK |->
      out_color.red == 8'd0 && out_color.green == 8'd0 &&
      out_color.blue == 8'd0 && out_color.alpha == 8'd0)
    else $error("error result with nonzero color");

  // a held item in the input register is not overwritten
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_char) && $stable(in_last))
    else $error("input register lost a held item");

  // a finished string always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    step && ends_string |=> out_valid)
    else $error("finished string gave no result");

  // an empty input register never blocks the channel
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> char_in.ready)
    else $error("input stalled with free register");
`endif

endmodule

FILE: test/tb_hex_color_string_parser_unit.sv
// tb_hex_color_string_parser_unit: self-checking bench for the hex color string parser
// depends on hcsp_pkg, the three hcsp channel interfaces and hex_color_string_parser_unit
// directed table first, then random strings under every config setting and idle pattern
`timescale 1ns / 1ps

module tb_hex_color_string_parser_unit;
  import hcsp_pkg::*;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  // one row of the directed table: a character item or a register write
  typedef struct packed {
    row_kind_t            kind;
    logic [7:0]           ch;
    logic                 last;
    logic                 empty;
    logic                 known;
    color_t               want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 reg_data;
  } row_t;

  localparam color_t UNTYPED      = '{8'h00, 8'h00, 8'h00, 8'h00, ST_OK};
  localparam color_t OPAQUE_WHITE = '{8'hff, 8'hff, 8'hff, 8'hff, ST_OK};
  localparam color_t DIGIT_ERR    = '{8'h00, 8'h00, 8'h00, 8'h00, ST_BAD_DIGIT};
  localparam color_t LONG_ERR     = '{8'h00, 8'h00, 8'h00, 8'h00, ST_TOO_LONG};
  localparam color_t ALPHA_ERR    = '{8'h00, 8'h00, 8'h00, 8'h00, ST_ALPHA_REQ};

  // lengths of the accepted forms, and characters just outside the hex ranges
  localparam logic [23:0] FORM_LENS = {4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8};
  localparam logic [47:0] NEAR_HEX  = {"/:@G", 8'h60, "g"};

  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst;

  hcsp_char_if  char_in ();
  hcsp_color_if color_out ();
  hcsp_cfg_if   cfg ();

  hex_color_string_parser_unit uut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .color_out (color_out),
    .cfg       (cfg)
  );

  always #6 clk = ~clk;

  // directed table
  row_t script [$] = '{
    '{ROW_CHAR, 8'h00, 1'b0, 1'b1, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "#",   1'b1, 1'b0, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "#",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "F",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "f",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "F",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "f",   1'b1, 1'b0, 1'b1, OPAQUE_WHITE, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, 8'h00, 1'b1, 1'b0, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, 8'hff, 1'b1, 1'b0, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    // unfinished string cut off by an empty item
    '{ROW_CHAR, "1",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, 8'hff, 1'b1, 1'b1, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, UNTYPED,   CFG_PERMISSIVE, 1'b1},
    '{ROW_CHAR, 8'h00, 1'b0, 1'b1, 1'b1, OPAQUE_WHITE, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "#",   1'b1, 1'b0, 1'b1, DIGIT_ERR, CFG_WITH_ALPHA, 1'b0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "0",   1'b1, 1'b0, 1'b1, LONG_ERR,  CFG_WITH_ALPHA, 1'b0},
    // require_alpha has no effect under three-component rules
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, UNTYPED,   CFG_REQ_ALPHA,  1'b1},
    '{ROW_CHAR, "a",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "B",   1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CHAR, "c",   1'b1, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, UNTYPED,   CFG_WITH_ALPHA, 1'b1},
    '{ROW_CHAR, "5",   1'b1, 1'b0, 1'b1, ALPHA_ERR, CFG_WITH_ALPHA, 1'b0}
  };

  // shadow parser state and the colors still owed by the block
  cfg_t   shadow_cfg;
  str_t   shadow_str;
  logic   shadow_first;
  color_t predicted;
  color_t expected_colors [$];
  color_t oldest;

  // side info that travels with the item on the char channel
  logic   row_known;
  color_t row_color;

  int idle_pct;
  int stall_pct;
  int mismatch_count;
  int item_count;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // advance the shadow parser by one item; returns 1 when a color is due
  function automatic logic parse_char(input logic [7:0] ch, input logic last,
                                      input logic empty, output color_t res);
    logic [3:0]  nib;
    logic        is_hex;
    logic [3:0]  n;
    logic [3:0]  limit;
    logic [31:0] v;
    logic        alpha_needed;
    res = UNTYPED;
    if (empty) begin
      // any unfinished string is dropped
      if (shadow_cfg.permissive) res = OPAQUE_WHITE;
      else res = DIGIT_ERR;
      shadow_str = '0;
      shadow_first = 1'b1;
      return 1'b1;
    end
    if (!(shadow_first && ch == "#")) begin
      // letters: low nibble of 'a'/'A' is 1, so +9 gives 10
      is_hex = 1'b1;
      nib = 4'd0;
      if (ch >= "0" && ch <= "9") nib = ch[3:0];
      else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) nib = ch[3:0] + 4'd9;
      else is_hex = 1'b0;
      if (shadow_str.digit_count < 4'd9) shadow_str.digit_count++;
      if (!is_hex) shadow_str.saw_bad_digit = 1'b1;
      else shadow_str.hex_acc = {shadow_str.hex_acc[27:0], nib};
    end
    shadow_first = 1'b0;
    if (!last) return 1'b0;

    // format the finished string
    n = shadow_str.digit_count;
    v = shadow_str.hex_acc;
    limit = shadow_cfg.with_alpha_mode ? 4'd8 : 4'd6;
    alpha_needed = shadow_cfg.with_alpha_mode && shadow_cfg.require_alpha;
    if (n > limit) res.status = ST_TOO_LONG;
    else if (shadow_str.saw_bad_digit || n == 4'd0) res.status = ST_BAD_DIGIT;
    else begin
      // a nibble repeated twice is the nibble times 17
      case (n)
        4'd8: begin
          res = '{v[31:24], v[23:16], v[15:8], v[7:0], ST_OK};
        end
        4'd6: begin
          if (alpha_needed) res.status = ST_ALPHA_REQ;
          else res = '{v[23:16], v[15:8], v[7:0], 8'hff, ST_OK};
        end
        4'd4: begin
          if (!shadow_cfg.with_alpha_mode) res.status = ST_BAD_PATTERN;
          else res = '{{2{v[15:12]}}, {2{v[11:8]}}, {2{v[7:4]}}, {2{v[3:0]}}, ST_OK};
        end
        4'd3: begin
          if (alpha_needed) res.status = ST_ALPHA_REQ;
          else res = '{{2{v[11:8]}}, {2{v[7:4]}}, {2{v[3:0]}}, 8'hff, ST_OK};
        end
        4'd2, 4'd1: begin
          if (!shadow_cfg.permissive) res.status = ST_BAD_PATTERN;
          else if (alpha_needed) res.status = ST_ALPHA_REQ;
          else if (n == 4'd2) res = '{v[7:0], v[7:0], v[7:0], 8'hff, ST_OK};
          else res = '{{2{v[3:0]}}, {2{v[3:0]}}, {2{v[3:0]}}, 8'hff, ST_OK};
        end
        default: res.status = ST_BAD_PATTERN;
      endcase
    end
    shadow_str = '0;
    shadow_first = 1'b1;
    return 1'b1;
  endfunction

  // follow accepted config writes and items
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg = '{with_alpha_mode: 1'b1, require_alpha: 1'b0, permissive: 1'b0};
      shadow_str = '0;
      shadow_first = 1'b1;
      expected_colors.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WITH_ALPHA: shadow_cfg.with_alpha_mode = cfg.data;
          CFG_REQ_ALPHA:  shadow_cfg.require_alpha = cfg.data;
          CFG_PERMISSIVE: shadow_cfg.permissive = cfg.data;
          default: ;
        endcase
      end
      if (char_in.valid && char_in.ready) begin
        if (parse_char(char_in.char_code, char_in.is_last, char_in.is_empty, predicted))
          expected_colors.push_back(row_known ? row_color : predicted);
      end
    end
  end

  // compare each accepted color with the oldest one owed
  always @(posedge clk) begin
    if (!rst && color_out.valid && color_out.ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("color with none pending, status", 8'(color_out.status), 8'h00);
      end else begin
        oldest = expected_colors.pop_front();
        if (color_out.red !== oldest.red) report_mismatch("red", color_out.red, oldest.red);
        if (color_out.green !== oldest.green)
          report_mismatch("green", color_out.green, oldest.green);
        if (color_out.blue !== oldest.blue) report_mismatch("blue", color_out.blue, oldest.blue);
        if (color_out.alpha !== oldest.alpha)
          report_mismatch("alpha", color_out.alpha, oldest.alpha);
        if (color_out.status !== oldest.status)
          report_mismatch("status", 8'(color_out.status), 8'(oldest.status));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    color_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // offer one item, with random idle cycles ahead of it
  task automatic push_char(input logic [7:0] ch, input logic last, input logic empty,
                           input logic known = 1'b0, input color_t want = UNTYPED);
    while ($urandom_range(99) < idle_pct) begin
      char_in.valid <= 1'b0;
      char_in.char_code <= 8'($urandom);
      @(posedge clk);
    end
    char_in.valid <= 1'b1;
    char_in.char_code <= ch;
    char_in.is_last <= last;
    char_in.is_empty <= empty;
    row_known <= known;
    row_color <= want;
    do @(posedge clk); while (!char_in.ready);
    item_count++;
  endtask

  // register write; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // let every owed color arrive, then let the pipeline settle
  task automatic drain();
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    logic [3:0] d;
    d = 4'($urandom);
    if (d < 4'd10) return "0" + d;
    return ($urandom_range(1) ? "A" : "a") + d - 8'd10;
  endfunction

  // one random string: mostly valid forms, some odd lengths, noise, cut-off strings and lone empty items
  task automatic send_string();
    int          kind;
    int          len;
    logic        noisy;
    logic        cut;
    logic [7:0]  ch;
    kind = $urandom_range(99);
    noisy = 1'b0;
    cut = 1'b0;
    if (kind < 5) begin
      push_char(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    if (kind < 75) len = FORM_LENS[4*$urandom_range(5) +: 4];
    else if (kind < 85) len = $urandom_range(12);
    else begin
      len = $urandom_range(1, 9);
      noisy = (kind < 95);
      cut = !noisy;
    end
    // a leading hash at random, and a lone hash when there are no digits
    if (len == 0 || $urandom_range(1)) push_char("#", len == 0, 1'b0);
    for (int i = 0; i < len; i++) begin
      ch = hex_char();
      if (noisy && $urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: ch = "#";
          1: ch = NEAR_HEX[8*$urandom_range(5) +: 8];
          default: ch = 8'($urandom);
        endcase
      end
      if (cut && i == len - 1) begin
        push_char(8'($urandom), 1'($urandom), 1'b1);
        return;
      end
      push_char(ch, i == len - 1, 1'b0);
    end
  endtask

  // stimulus
  initial begin
    int   seg_start;
    int   combo;
    logic prev_cfg;
    rst = 1'b1;
    char_in.valid = 1'b0;
    char_in.char_code = 8'h00;
    char_in.is_last = 1'b0;
    char_in.is_empty = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_WITH_ALPHA;
    cfg.data = 1'b0;
    row_known = 1'b0;
    row_color = UNTYPED;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    item_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    prev_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (!prev_cfg) drain();
        write_reg(script[i].reg_idx, script[i].reg_data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg.valid <= 1'b0;
        push_char(script[i].ch, script[i].last, script[i].empty, script[i].known,
                  script[i].want);
        prev_cfg = 1'b0;
      end
    end

    // random strings: every config setting under each idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (int k = 0; k < 8; k++) begin
        if (k != 0) drain();
        combo = (k + 3 * ph) % 8;
        write_reg(CFG_WITH_ALPHA, combo[2]);
        write_reg(CFG_REQ_ALPHA, combo[1]);
        write_reg(CFG_PERMISSIVE, combo[0]);
        cfg.valid <= 1'b0;
        seg_start = item_count;
        while (item_count - seg_start < 21) send_string();
      end
    end

    drain();
    if (mismatch_count == 0) $display("tb_hex_color_string_parser_unit OK");
    else $display("tb_hex_color_string_parser_unit NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_hex_color_string_parser_unit NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hcsp_pkg.sv
rtl/hcsp_char_if.sv
rtl/hcsp_color_if.sv
rtl/hcsp_cfg_if.sv
rtl/hcsp_state.sv
rtl/hcsp_format.sv
rtl/hex_color_string_parser_unit.sv
test/tb_hex_color_string_parser_unit.sv
